// File: rtl/hrd_pkg.sv
// Package for the HTTP response deframer: types, constants and helpers.
// Used by all modules in rtl/.
package hrd_pkg;

  localparam int COUNT_BITS_DEF = 32;
  localparam logic [31:0] MAX_BODY_RESET = 32'd1048576;

  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_CLOSE = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [1:0] END_LENGTH = 2'd0;
  localparam logic [1:0] END_ZERO   = 2'd1;
  localparam logic [1:0] END_CLOSED = 2'd2;
  localparam logic [1:0] END_LIMIT  = 2'd3;

  typedef enum logic [5:0] {
    PH_HEADER      = 6'b000001,
    PH_CHUNK_SIZE  = 6'b000010,
    PH_CHUNK_DATA  = 6'b000100,
    PH_BY_LENGTH   = 6'b001000,
    PH_UNTIL_CLOSE = 6'b010000,
    PH_DONE        = 6'b100000
  } phase_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] body_byte;
    logic       is_last;
    logic [1:0] end_reason;
    logic [9:0] status_code;
    logic       keep_alive;
    logic       chunked_mode;
    logic [31:0] body_length;
  } result_t;

  function automatic logic [7:0] pfx_char(input logic [1:0] k, input logic [5:0] p);
    logic [8*26-1:0] s0, s1, s2;
    logic [7:0] r;
    s0 = {80'd0, "content-length: "};
    s1 = "transfer-encoding: chunked";
    s2 = {32'd0, "connection: keep-alive"};
    r = 8'd0;
    case (k)
      2'd0: if (p < 6'd16) r = s0[8*(15 - p[4:0]) +: 8];
      2'd1: if (p < 6'd26) r = s1[8*(25 - p[4:0]) +: 8];
      2'd2: if (p < 6'd22) r = s2[8*(21 - p[4:0]) +: 8];
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] pfx_size(input logic [1:0] k);
    logic [5:0] r;
    case (k)
      2'd0: r = 6'd16;
      2'd1: r = 6'd26;
      default: r = 6'd22;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/http_response_deframer.sv
// Top level of the HTTP response deframer: configuration register and channel glue.
// Depends on hrd_pkg, hrd_core and hrd_out_buf.
//
// The input channel carries one request per cycle while in_tready is high: an
// op (received byte, connection closed, start new response) and the received
// byte. The block parses the header byte by byte, then delivers body bytes one
// per result on the output channel, each tagged with status code, header flags
// and the running body length; the result that ends a response has is_last set
// and gives the end reason. A result is registered in the parser at the edge
// that accepts its request and moves into the result buffer at the next edge,
// from where it can be taken on out_tvalid; many requests cause no result.
// Throughput is one request per cycle while in_tready is high; the per-byte
// parser update is the single register stage that sets it. Results wait in a
// two-entry buffer; in_tready drops while it holds two results, or one that
// is not leaving in that cycle, since another result may still be on its way.
// Reset clears all parser state and sets max_body_bytes to 1048576.
// cfg_wr_en writes max_body_bytes; write it only while the block is idle.
module http_response_deframer #(
  parameter int COUNT_BITS = hrd_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [1:0] op, [9:2] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [0] has_byte, [8:1] body_byte, [9] is_last,
                                  // [11:10] end_reason, [21:12] status_code,
                                  // [22] keep_alive, [23] chunked_mode,
                                  // [55:24] body_length
  output logic        out_tlast
);

  logic [31:0] max_r;
  logic step, rv, space;
  hrd_pkg::result_t res, ores;

  always_ff @(posedge clk) begin
    if (!rst_n) max_r <= hrd_pkg::MAX_BODY_RESET;
    else if (cfg_wr_en) max_r <= cfg_wr_data;
  end

  assign in_tready = space;
  assign step = in_tvalid && in_tready;

  hrd_core #(.COUNT_BITS(COUNT_BITS)) u_core (
    .clk(clk), .rst_n(rst_n), .step(step), .op(in_tdata[1:0]), .rx_byte(in_tdata[9:2]),
    .max_body(max_r), .res_valid(rv), .res(res)
  );

  hrd_out_buf u_buf (
    .clk(clk), .rst_n(rst_n), .in_valid(rv), .in_res(res), .space(space),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_res(ores)
  );

  assign out_tdata = {ores.body_length, ores.chunked_mode, ores.keep_alive, ores.status_code,
                      ores.end_reason, ores.is_last, ores.body_byte, ores.has_byte};
  assign out_tlast = ores.is_last;

endmodule

// File: rtl/hrd_core.sv
// Parser state and per-byte next-state logic of the HTTP response deframer.
// Depends on hrd_pkg.
module hrd_core #(
  parameter int COUNT_BITS = hrd_pkg::COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [1:0]       op,
  input  logic [7:0]       rx_byte,
  input  logic [31:0]      max_body,
  output logic             res_valid,
  output hrd_pkg::result_t res
);

  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  hrd_pkg::phase_t ph_r, ph_nxt;
  logic [5:0] lpos_r, lpos_nxt;
  logic [2:0] pm_r, pm_nxt;
  logic [3:0] hbi_r, hbi_nxt;
  logic [9:0] st_r, st_nxt;
  logic [1:0] lbt_r, lbt_nxt;
  logic [COUNT_BITS-1:0] len_r, len_nxt, cb_r, cb_nxt, cd_r, cd_nxt, bc_r, bc_nxt;
  logic ka_r, ka_nxt, ch_r, ch_nxt;

  logic [7:0] c, lc;
  logic is_dig, is_hex, is_ws;
  logic [3:0] dv, hv;
  logic [COUNT_BITS+3:0] len_mul, cb_mul;
  logic [COUNT_BITS-1:0] next_bc, next_cd;
  logic [63:0] nb64, mb64;
  logic emit, e_has, e_last;
  logic [1:0] e_why;
  logic [1:0] kk;

  always_comb begin
    c = rx_byte;
    lc = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    is_dig = (c >= 8'h30 && c <= 8'h39);
    dv = c[3:0];
    is_hex = 1'b1;
    hv = 4'd0;
    if (is_dig) hv = c[3:0];
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) hv = c[3:0] + 4'd9;
    else is_hex = 1'b0;
    is_ws = (c == 8'h20) || (c == 8'h09);
    len_mul = {4'd0, len_r} * (COUNT_BITS + 4)'(10) + (COUNT_BITS + 4)'(dv);
    cb_mul = {cb_r, 4'd0} + (COUNT_BITS + 4)'(hv);
    next_bc = (bc_r == CMAX) ? bc_r : bc_r + 1'b1;
    next_cd = (cd_r == CMAX) ? cd_r : cd_r + 1'b1;
    nb64 = 64'(next_bc);
    mb64 = {32'd0, max_body};

    ph_nxt = ph_r; lpos_nxt = lpos_r; pm_nxt = pm_r; hbi_nxt = hbi_r;
    st_nxt = st_r; lbt_nxt = lbt_r; len_nxt = len_r; cb_nxt = cb_r;
    cd_nxt = cd_r; bc_nxt = bc_r; ka_nxt = ka_r; ch_nxt = ch_r;
    emit = 1'b0; e_has = 1'b0; e_last = 1'b0; e_why = hrd_pkg::END_LENGTH;
    kk = 2'd0;

    if (step) begin
      case (op)
        hrd_pkg::OP_START: begin
          ph_nxt = hrd_pkg::PH_HEADER; lpos_nxt = '0; pm_nxt = 3'b111; hbi_nxt = '0;
          st_nxt = '0; lbt_nxt = '0; len_nxt = '0; cb_nxt = '0; cd_nxt = '0;
          bc_nxt = '0; ka_nxt = 1'b0; ch_nxt = 1'b0;
        end
        hrd_pkg::OP_CLOSE: begin
          if (ph_r != hrd_pkg::PH_DONE) begin
            emit = 1'b1; e_last = 1'b1; e_why = hrd_pkg::END_CLOSED;
          end
        end
        hrd_pkg::OP_BYTE: begin
          case (ph_r)
            hrd_pkg::PH_HEADER: begin
              if (hbi_r >= 4'd9 && hbi_r < 4'd12) begin
                if (is_dig) begin
                  st_nxt = 10'(st_r * 10'd10 + 10'(dv));
                  hbi_nxt = hbi_r + 4'd1;
                end else hbi_nxt = 4'd12;
              end else if (hbi_r < 4'd12) hbi_nxt = hbi_r + 4'd1;
              for (int k = 0; k < 3; k++) begin
                kk = 2'(k);
                if (pm_r[k]) begin
                  if (lpos_r < hrd_pkg::pfx_size(kk)) begin
                    if (lc != hrd_pkg::pfx_char(kk, lpos_r)) pm_nxt[k] = 1'b0;
                    else if (lpos_r == hrd_pkg::pfx_size(kk) - 6'd1) begin
                      if (k == 0) len_nxt = '0;
                      else if (k == 1) ch_nxt = 1'b1;
                      else ka_nxt = 1'b1;
                    end
                  end else if (k == 0) begin
                    if (is_dig)
                      len_nxt = (len_mul[COUNT_BITS+3:COUNT_BITS] != 4'd0) ? CMAX
                                : len_mul[COUNT_BITS-1:0];
                    else pm_nxt[0] = 1'b0;
                  end
                end
              end
              if (c == 8'h0A) begin
                lpos_nxt = '0; pm_nxt = 3'b111;
              end else if (lpos_r < 6'd63) lpos_nxt = lpos_r + 6'd1;
              if (c == 8'h0D) lbt_nxt = (lbt_r == 2'd2) ? 2'd3 : 2'd1;
              else if (c == 8'h0A) begin
                if (lbt_r == 2'd3) begin
                  lbt_nxt = '0;
                  if (ch_nxt) begin
                    ph_nxt = hrd_pkg::PH_CHUNK_SIZE; lpos_nxt = '0; pm_nxt = 3'b001;
                    cb_nxt = '0;
                  end else if (len_nxt != '0) ph_nxt = hrd_pkg::PH_BY_LENGTH;
                  else ph_nxt = hrd_pkg::PH_UNTIL_CLOSE;
                end else lbt_nxt = (lbt_r == 2'd1) ? 2'd2 : 2'd0;
              end else lbt_nxt = '0;
            end
            hrd_pkg::PH_CHUNK_SIZE: begin
              if (c == 8'h0A) begin
                if (lpos_r == 6'd0) begin
                  lpos_nxt = '0; pm_nxt = 3'b001; cb_nxt = '0;
                end else if (cb_r == '0) begin
                  emit = 1'b1; e_last = 1'b1; e_why = hrd_pkg::END_ZERO;
                end else begin
                  ph_nxt = hrd_pkg::PH_CHUNK_DATA; cd_nxt = '0;
                end
              end else if (c == 8'h0D) pm_nxt = 3'b000;
              else begin
                if (pm_r[0]) begin
                  if (is_hex)
                    cb_nxt = (cb_mul[COUNT_BITS+3:COUNT_BITS] != 4'd0) ? CMAX
                             : cb_mul[COUNT_BITS-1:0];
                  else if (!(is_ws && lpos_r == 6'd0)) pm_nxt = 3'b000;
                end
                if ((!is_ws || lpos_r != 6'd0 || !pm_nxt[0]) && lpos_r < 6'd63)
                  lpos_nxt = lpos_r + 6'd1;
              end
            end
            hrd_pkg::PH_CHUNK_DATA, hrd_pkg::PH_BY_LENGTH, hrd_pkg::PH_UNTIL_CLOSE: begin
              emit = 1'b1;
              if (ph_r == hrd_pkg::PH_BY_LENGTH && next_bc >= len_r) begin
                bc_nxt = next_bc; e_has = 1'b1; e_last = 1'b1; e_why = hrd_pkg::END_LENGTH;
              end else if (nb64 > mb64) begin
                e_last = 1'b1; e_why = hrd_pkg::END_LIMIT;
              end else begin
                bc_nxt = next_bc; e_has = 1'b1;
                if (ph_r == hrd_pkg::PH_CHUNK_DATA) begin
                  cd_nxt = next_cd;
                  if (next_cd >= cb_r) begin
                    ph_nxt = hrd_pkg::PH_CHUNK_SIZE; lpos_nxt = '0; pm_nxt = 3'b001;
                    cb_nxt = '0;
                  end
                end
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      if (emit && e_last) ph_nxt = hrd_pkg::PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= hrd_pkg::PH_HEADER; lpos_r <= '0; pm_r <= 3'b111; hbi_r <= '0;
      st_r <= '0; lbt_r <= '0; len_r <= '0; cb_r <= '0; cd_r <= '0; bc_r <= '0;
      ka_r <= 1'b0; ch_r <= 1'b0; res_valid <= 1'b0;
    end else begin
      ph_r <= ph_nxt; lpos_r <= lpos_nxt; pm_r <= pm_nxt; hbi_r <= hbi_nxt;
      st_r <= st_nxt; lbt_r <= lbt_nxt; len_r <= len_nxt; cb_r <= cb_nxt;
      cd_r <= cd_nxt; bc_r <= bc_nxt; ka_r <= ka_nxt; ch_r <= ch_nxt;
      res_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res.has_byte <= e_has;
      res.body_byte <= e_has ? c : 8'd0;
      res.is_last <= e_last;
      res.end_reason <= e_last ? e_why : 2'd0;
      res.status_code <= st_r;
      res.keep_alive <= ka_r;
      res.chunked_mode <= ch_r;
      res.body_length <= (64'(bc_nxt) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(bc_nxt);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.is_last |-> ph_r == hrd_pkg::PH_DONE || $past(op) == hrd_pkg::OP_START)
    else $error("ending result without done phase");
  assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res.has_byte |-> res.is_last)
    else $error("empty result that does not end the response");
  assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.end_reason == hrd_pkg::END_LIMIT |-> !res.has_byte)
    else $error("byte delivered past the size limit");

endmodule

// File: rtl/hrd_out_buf.sv
// Two-entry skid buffer on the result channel of the HTTP response deframer.
// Depends on hrd_pkg.
module hrd_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  hrd_pkg::result_t in_res,
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output hrd_pkg::result_t out_res
);

  hrd_pkg::result_t mem_r [2];
  logic rp_r, wp_r;
  logic [1:0] cnt_r;
  logic push, pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_res = mem_r[rp_r];
  assign pop = out_valid && out_ready;
  assign push = in_valid;
  assign space = (cnt_r == 2'd0) || (cnt_r == 2'd1 && pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r <= 1'b0; wp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_res;
  end

  assert property (@(posedge clk) disable iff (!rst_n) !(push && cnt_r == 2'd2 && !pop))
    else $error("result buffer overflow");

endmodule
